[rtl/pwft_pkg.sv]
// ----------------------------------------------------------------------------
// pwft_pkg: shared types and constants of the pulse width frame transmitter
// Beat layouts, frame fields, phase codes and register indexes.
// ----------------------------------------------------------------------------
package pwft_pkg;

    // One request beat: a command or a single time tick
    typedef struct packed {
        logic       req_type;
        logic [1:0] cmd_function;
        logic [1:0] cmd_parameter;
        logic [7:0] cmd_value;
        logic [1:0] line_select;
    } req_t;

    // One result beat: line levels and status after the request
    typedef struct packed {
        logic line_x_level;
        logic line_y_level;
        logic line_z_level;
        logic busy_res;
        logic cmd_accepted;
        logic frame_done;
    } res_t;

    // Request kinds
    localparam logic REQ_COMMAND = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // Frame layout, sent MSB first
    localparam int          FRAME_BITS  = 38;
    localparam int          COUNT_BITS  = 6;
    localparam logic [11:0] FRAME_START = 12'h801;
    localparam logic [1:0]  FRAME_DUMMY = 2'd2;
    localparam logic [11:0] FRAME_END   = 12'h7FE;

    // Number of lines; a select at or above it drives nothing
    localparam logic [1:0] LINE_COUNT = 2'd3;

    // Phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_LOW   = 2'd1;
    localparam logic [1:0] PH_HIGH  = 2'd2;
    localparam logic [1:0] PH_TRAIL = 2'd3;

    // Configuration register indexes and reset values
    localparam int CFG_INDEX_BITS = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_TICKS      = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_HIGH     = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_HIGH      = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRAILING_TICKS = 8'd3;

    localparam logic [7:0] RST_LOW_TICKS      = 8'd25;
    localparam logic [7:0] RST_SHORT_HIGH     = 8'd2;
    localparam logic [7:0] RST_LONG_HIGH      = 8'd130;
    localparam logic [7:0] RST_TRAILING_TICKS = 8'd10;

endpackage

[rtl/pwft_out_skid.sv]
// ----------------------------------------------------------------------------
// pwft_out_skid: result register with one skid entry
// Lets the core take a new beat while a finished result is still held.
// ----------------------------------------------------------------------------
module pwft_out_skid
    import pwft_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    logic pop;

    assign pop       = out_valid_reg && !res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            // Refill the output stage: skid entry first, else the new beat
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

[rtl/pulse_width_frame_transmitter_unit.sv]
// ----------------------------------------------------------------------------
// pulse_width_frame_transmitter_unit: pulse width coded single wire writer
// Builds a 38-bit frame from a command and times it out on one of three lines,
// one request beat (command or tick) in, one result beat out.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  req     | in        | req_valid/req_stall | req_data  (req_t)
//  res     | out       | res_valid/res_stall | res_data  (res_t)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  Request beats: one may be taken in every cycle.
//  A beat's result goes to the result register, or the skid entry on a stall.
//  The frame state updates at the beat itself, so a tick is one req beat.
//  Reset: registers at their reset values, phase idle, all lines high.
//  A stalled result parks in a skid entry; req_stall rises only when it is
//  occupied. cfg_ready is always high.
//
module pulse_width_frame_transmitter_unit
    import pwft_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  req_t                      req_data,
    output logic                      res_valid,
    input  logic                      res_stall,
    output res_t                      res_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [7:0]                cfg_data
);

    localparam int TW = TICK_COUNT_WIDTH;

    // Configuration registers
    logic [7:0] low_ticks_reg;
    logic [7:0] short_high_reg;
    logic [7:0] long_high_reg;
    logic [7:0] trailing_ticks_reg;

    // Frame state
    logic [FRAME_BITS-1:0] frame_shift_reg, frame_shift_next;
    logic [COUNT_BITS-1:0] bits_left_reg, bits_left_next;
    logic [1:0]            phase_reg, phase_next;
    logic [TW-1:0]         tick_count_reg, tick_count_next;
    logic [1:0]            active_line_reg, active_line_next;
    logic [2:0]            line_levels_reg, line_levels_next;

    logic    accept;
    logic    skid_full;
    res_t    result;
    logic    accepted_flag;
    logic    done_flag;
    logic [TW-1:0] tick_dec;
    logic    line_drive;
    logic    line_level;

    // A zero register behaves as one tick
    function automatic logic [TW-1:0] at_least_one(input logic [7:0] v);
        logic [TW-1:0] w;
        w = TW'(v);
        return (v == 8'd0) ? TW'(1) : w;
    endfunction

    assign cfg_ready = 1'b1;
    assign req_stall = skid_full;
    assign accept    = req_valid && !skid_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_ticks_reg      <= RST_LOW_TICKS;
            short_high_reg     <= RST_SHORT_HIGH;
            long_high_reg      <= RST_LONG_HIGH;
            trailing_ticks_reg <= RST_TRAILING_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_TICKS:      low_ticks_reg      <= cfg_data;
                CFG_SHORT_HIGH:     short_high_reg     <= cfg_data;
                CFG_LONG_HIGH:      long_high_reg      <= cfg_data;
                CFG_TRAILING_TICKS: trailing_ticks_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign tick_dec = tick_count_reg - TW'(1);

    // Next frame state for the beat on the request side
    always_comb
    begin
        frame_shift_next = frame_shift_reg;
        bits_left_next   = bits_left_reg;
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        active_line_next = active_line_reg;
        line_drive       = 1'b0;
        line_level       = 1'b0;
        accepted_flag    = 1'b0;
        done_flag        = 1'b0;

        if (req_data.req_type == REQ_COMMAND)
        begin
            // Start a frame only from idle; drop commands while busy
            if (phase_reg == PH_IDLE)
            begin
                frame_shift_next = {FRAME_START, req_data.cmd_function,
                                    req_data.cmd_parameter, FRAME_DUMMY,
                                    req_data.cmd_value, FRAME_END};
                bits_left_next   = COUNT_BITS'(FRAME_BITS);
                active_line_next = req_data.line_select;
                phase_next       = PH_LOW;
                tick_count_next  = at_least_one(low_ticks_reg);
                line_drive       = 1'b1;
                line_level       = 1'b0;
                accepted_flag    = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_count_next = tick_dec;
            if (tick_dec == TW'(0))
            begin
                case (phase_reg)
                    PH_LOW:
                    begin
                        // Release the line for the length that the bit calls for
                        phase_next      = PH_HIGH;
                        tick_count_next = frame_shift_reg[FRAME_BITS-1]
                                          ? at_least_one(long_high_reg)
                                          : at_least_one(short_high_reg);
                        line_drive      = 1'b1;
                        line_level      = 1'b1;
                    end
                    PH_HIGH:
                    begin
                        // Advance to the next bit or to the trailing low
                        frame_shift_next = {frame_shift_reg[FRAME_BITS-2:0], 1'b0};
                        bits_left_next   = bits_left_reg - COUNT_BITS'(1);
                        if (bits_left_reg != COUNT_BITS'(1))
                        begin
                            phase_next      = PH_LOW;
                            tick_count_next = at_least_one(low_ticks_reg);
                        end
                        else
                        begin
                            phase_next      = PH_TRAIL;
                            tick_count_next = at_least_one(trailing_ticks_reg);
                        end
                        line_drive = 1'b1;
                        line_level = 1'b0;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done_flag  = 1'b1;
                    end
                endcase
            end
        end

        // Drive the active line; a select of three touches nothing
        line_levels_next = line_levels_reg;
        if (line_drive && (active_line_next < LINE_COUNT))
        begin
            line_levels_next[active_line_next] = line_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg <= '0;
            bits_left_reg   <= '0;
            phase_reg       <= PH_IDLE;
            tick_count_reg  <= '0;
            active_line_reg <= '0;
            line_levels_reg <= 3'b111;
        end
        else if (accept)
        begin
            frame_shift_reg <= frame_shift_next;
            bits_left_reg   <= bits_left_next;
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            active_line_reg <= active_line_next;
            line_levels_reg <= line_levels_next;
        end
    end

    always_comb
    begin
        result.line_x_level = line_levels_next[0];
        result.line_y_level = line_levels_next[1];
        result.line_z_level = line_levels_next[2];
        result.busy_res     = (phase_next != PH_IDLE);
        result.cmd_accepted = accepted_flag;
        result.frame_done   = done_flag;
    end

    pwft_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (skid_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // A started frame always reports busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.cmd_accepted) |-> res_data.busy_res)
        else $error("accepted command without busy");

    // The end of the trailing low always leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_data.frame_done) |-> !res_data.busy_res)
        else $error("frame done while still busy");

    // A running phase never holds an expired tick count
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (tick_count_reg != TW'(0)))
        else $error("zero tick count in a running phase");

    // Bit phases always have bits left to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOW || phase_reg == PH_HIGH) |-> (bits_left_reg != '0))
        else $error("bit phase with no bits left");

    // A command taken while busy leaves the frame state alone
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_data.req_type == REQ_COMMAND && phase_reg != PH_IDLE)
        |=> $stable(frame_shift_reg))
        else $error("busy command changed the frame");

endmodule

[bench/pwft_line_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwft_line_monitor: prediction and checking of the frame transmitter results
// Watches the request, result and register write channels, keeps its own copy
// of the frame timing state and compares every result beat, field by field,
// with the line levels and status expected for it.
// ----------------------------------------------------------------------------
module pwft_line_monitor
    import pwft_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  req_t                      req_data,
    input  logic                      res_valid,
    input  logic                      res_stall,
    input  res_t                      res_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [7:0]                cfg_data,
    output int                        fails,
    output int                        pending,
    output logic                      frame_busy
);

    typedef struct packed {
        logic [FRAME_BITS-1:0]       frame;
        logic [COUNT_BITS-1:0]       left;
        logic [1:0]                  phase;
        logic [TICK_COUNT_WIDTH-1:0] count;
        logic [1:0]                  sel;
        logic [2:0]                  levels;
    } line_state_t;

    line_state_t st;
    logic [7:0]  low_cfg;
    logic [7:0]  short_cfg;
    logic [7:0]  long_cfg;
    logic [7:0]  trail_cfg;
    res_t        expected_levels[$];

    assign frame_busy = (st.phase != PH_IDLE);

    // A register holding zero times out after a single tick
    function automatic logic [TICK_COUNT_WIDTH-1:0] span(input logic [7:0] v);
        return (v == 8'd0) ? TICK_COUNT_WIDTH'(1) : TICK_COUNT_WIDTH'(v);
    endfunction

    function automatic void set_level(inout line_state_t s, input logic level);
        if (s.sel < LINE_COUNT)
            s.levels[s.sel] = level;
    endfunction

    // Apply one request beat to the state and return the result beat it gives
    function automatic res_t advance_frame(inout line_state_t s, input req_t r);
        res_t beat_res;
        logic bit_now;
        beat_res = '0;
        if (r.req_type == REQ_COMMAND) begin
            if (s.phase == PH_IDLE) begin
                s.frame = {FRAME_START, r.cmd_function, r.cmd_parameter, FRAME_DUMMY,
                           r.cmd_value, FRAME_END};
                s.left  = COUNT_BITS'(FRAME_BITS);
                s.sel   = r.line_select;
                s.phase = PH_LOW;
                s.count = span(low_cfg);
                set_level(s, 1'b0);
                beat_res.cmd_accepted = 1'b1;
            end
        end
        else if (s.phase != PH_IDLE) begin
            s.count = s.count - 1'b1;
            if (s.count == '0) begin
                case (s.phase)
                    PH_LOW:
                    begin
                        bit_now = s.frame[FRAME_BITS-1];
                        s.phase = PH_HIGH;
                        s.count = span(bit_now ? long_cfg : short_cfg);
                        set_level(s, 1'b1);
                    end
                    PH_HIGH:
                    begin
                        s.frame = s.frame << 1;
                        s.left  = s.left - 1'b1;
                        if (s.left != '0) begin
                            s.phase = PH_LOW;
                            s.count = span(low_cfg);
                        end
                        else begin
                            s.phase = PH_TRAIL;
                            s.count = span(trail_cfg);
                        end
                        set_level(s, 1'b0);
                    end
                    PH_TRAIL:
                    begin
                        s.phase = PH_IDLE;
                        beat_res.frame_done = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        beat_res.line_x_level = s.levels[0];
        beat_res.line_y_level = s.levels[1];
        beat_res.line_z_level = s.levels[2];
        beat_res.busy_res     = (s.phase != PH_IDLE);
        return beat_res;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        line_state_t nx;
        res_t        want;
        if (!rst_n) begin
            st <= '{frame: '0, left: '0, phase: PH_IDLE, count: '0, sel: '0, levels: 3'b111};
            low_cfg   <= RST_LOW_TICKS;
            short_cfg <= RST_SHORT_HIGH;
            long_cfg  <= RST_LONG_HIGH;
            trail_cfg <= RST_TRAILING_TICKS;
            expected_levels.delete();
            fails = 0;
            pending <= 0;
        end
        else begin
            // Match first: the result of a request taken at this edge is not out yet
            if (res_valid && !res_stall) begin
                if (expected_levels.size() == 0) begin
                    $error("result beat %b with nothing expected", res_data);
                    fails++;
                end
                else begin
                    want = expected_levels.pop_front();
                    check_field("line_x_level", want.line_x_level, res_data.line_x_level);
                    check_field("line_y_level", want.line_y_level, res_data.line_y_level);
                    check_field("line_z_level", want.line_z_level, res_data.line_z_level);
                    check_field("busy_res", want.busy_res, res_data.busy_res);
                    check_field("cmd_accepted", want.cmd_accepted, res_data.cmd_accepted);
                    check_field("frame_done", want.frame_done, res_data.frame_done);
                end
            end
            if (req_valid && !req_stall) begin
                nx = st;
                expected_levels.push_back(advance_frame(nx, req_data));
                st <= nx;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LOW_TICKS:      low_cfg   <= cfg_data;
                    CFG_SHORT_HIGH:     short_cfg <= cfg_data;
                    CFG_LONG_HIGH:      long_cfg  <= cfg_data;
                    CFG_TRAILING_TICKS: trail_cfg <= cfg_data;
                    default: ;
                endcase
            end
            pending <= expected_levels.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the pulse width frame transmitter
// Drives request beats (commands and ticks) and register writes, stalls the
// result side at random, and leaves prediction and checking to the line
// monitor placed beside the block. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb_top;
    import pwft_pkg::*;

    localparam int TICK_BITS      = 8;
    // Stop the random part once about this many request beats have gone in,
    // directed ones included
    localparam int ITEMS          = 1900;
    // Length of the receiver hold-off that fills the block and stalls its input
    localparam int SQUEEZE_CYCLES = 200;
    // Cycles without any accepted beat before the run is declared hung
    localparam int QUIET_LIMIT    = 2000;
    // Index outside the register map; a write there must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 8'd200;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    req_t                      req_data  = '0;
    logic                      res_valid;
    logic                      res_stall = 1'b0;
    res_t                      res_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [7:0]                cfg_data  = '0;

    int   fails;
    int   pending;
    logic frame_busy;

    // Set by the stimulus: no idling on either side while high
    bit steady = 1'b0;
    // Hold-off requests from the stimulus and how many the receiver has served
    int squeeze_asked  = 0;
    int squeeze_served = 0;
    int quiet = 0;
    int sent  = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pulse_width_frame_transmitter_unit #(
        .TICK_COUNT_WIDTH(TICK_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwft_line_monitor #(
        .TICK_COUNT_WIDTH(TICK_BITS)
    ) frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fails      (fails),
        .pending    (pending),
        .frame_busy (frame_busy)
    );

    // Mostly no pause, often a short one, now and then a long one
    function automatic int pause_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Random payload; a tick ignores everything but the request kind
    function automatic req_t random_beat(input logic kind);
        req_t b;
        b.req_type      = kind;
        b.cmd_function  = 2'($urandom);
        b.cmd_parameter = 2'($urandom);
        b.cmd_value     = 8'($urandom);
        b.line_select   = 2'($urandom);
        return b;
    endfunction

    function automatic req_t cmd_beat(input logic [1:0] fn, input logic [1:0] prm,
                                      input logic [7:0] val, input logic [1:0] sel);
        return '{req_type: REQ_COMMAND, cmd_function: fn, cmd_parameter: prm,
                 cmd_value: val, line_select: sel};
    endfunction

    // Offer one request beat after an optional pause; return at the accepting edge.
    // Hold valid and payload steady while the block stalls.
    task automatic offer(input req_t beat);
        int gap;
        gap = steady ? 0 : pause_len();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sent++;
    endtask

    // Feed ticks until one goes in while the frame is already over. frame_busy is
    // sampled at the accepting edge, so it still shows the state before that beat;
    // the extra tick lands on an idle block and changes nothing.
    task automatic run_out_frame();
        do
            offer(random_beat(REQ_TICK));
        while (frame_busy);
    endtask

    // Drop valid and wait until every expected result beat has come back
    task automatic quiesce();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // Also wait out the one result register and the one skid entry
        repeat (4) @(posedge clk);
    endtask

    // Leave cfg_valid high so writes can go back to back
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] low, input logic [7:0] short_hi,
                              input logic [7:0] long_hi, input logic [7:0] trail);
        write_reg(CFG_LOW_TICKS, low);
        write_reg(CFG_SHORT_HIGH, short_hi);
        write_reg(CFG_LONG_HIGH, long_hi);
        write_reg(CFG_TRAILING_TICKS, trail);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall runs, a long hold-off on request, else none while steady
    initial begin : receiver
        int stall_run;
        @(posedge clk);
        forever begin
            if (squeeze_served != squeeze_asked) begin
                res_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
                squeeze_served++;
            end
            else if (steady) begin
                res_stall <= 1'b0;
                @(posedge clk);
            end
            else begin
                stall_run = pause_len();
                if (stall_run > 0) begin
                    res_stall <= 1'b1;
                    repeat (stall_run) @(posedge clk);
                end
                res_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if nothing at all is accepted for too long
    always @(posedge clk) begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin : stimulus
        int round;
        int frames;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: a tick on an idle block, a frame with all-ones fields on line 0,
        // and a command refused because that frame is still going. Run the
        // first two bits (a one, then a zero) at the reset tick counts.
        offer(random_beat(REQ_TICK));
        offer(cmd_beat(2'd3, 2'd3, 8'hFF, 2'd0));
        offer(cmd_beat(2'd0, 2'd0, 8'h00, 2'd1));
        repeat (25 + 130 + 25 + 2)
            offer(random_beat(REQ_TICK));
        // Shorten the bit timing for the rest of the frame; the trailing low
        // keeps its reset length
        quiesce();
        write_reg(CFG_LOW_TICKS, 8'd1);
        write_reg(CFG_SHORT_HIGH, 8'd1);
        write_reg(CFG_LONG_HIGH, 8'd1);
        cfg_valid <= 1'b0;
        run_out_frame();
        quiesce();

        // Shortest timing. Line 0 stays low from the last frame while the
        // next ones go out on lines 1 and 2; select 3 moves no line at all.
        write_reg(CFG_UNMAPPED, 8'($urandom));
        write_regs(8'd1, 8'd1, 8'd1, 8'd1);
        offer(cmd_beat(2'd0, 2'd1, 8'h00, 2'd1));
        run_out_frame();
        offer(cmd_beat(2'd1, 2'd2, 8'hA5, 2'd2));
        run_out_frame();
        offer(cmd_beat(2'd2, 2'd0, 8'h5A, 2'd3));
        run_out_frame();
        quiesce();

        // Zero in every register must time out like one
        write_regs(8'd0, 8'd0, 8'd0, 8'd0);
        offer(cmd_beat(2'd3, 2'd3, 8'h3C, 2'd0));
        run_out_frame();
        quiesce();

        // Longest count: the trailing low runs the full 8-bit tick count,
        // no idling to keep the run short
        write_regs(8'd1, 8'd1, 8'd1, 8'd255);
        steady = 1'b1;
        offer(random_beat(REQ_COMMAND));
        run_out_frame();
        steady = 1'b0;

        // Random part: well-formed frames with random content, some stray
        // commands thrown in while a frame is going
        for (round = 0; sent < ITEMS; round++) begin
            quiesce();
            case (round % 4)
                0: write_regs(8'd1, 8'd1, 8'd1, 8'd1);
                1: write_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                              8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)));
                2: write_regs(8'($urandom_range(1, 3)), 8'd1,
                              8'($urandom_range(5, 12)), 8'($urandom_range(1, 20)));
                default: write_regs(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                                    8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
            endcase
            for (frames = 0; frames < 2; frames++) begin
                // First frame of a round: hold the receiver off and keep offering
                if (frames == 0) begin
                    squeeze_asked++;
                    steady = 1'b1;
                end
                else
                    steady = ($urandom_range(0, 4) == 0);
                offer(random_beat(REQ_COMMAND));
                do begin
                    if ($urandom_range(0, 99) < 8)
                        offer(random_beat(REQ_COMMAND));
                    else
                        offer(random_beat(REQ_TICK));
                end while (frame_busy);
            end
            steady = 1'b0;
            // A stray command may have started one more frame: finish it
            run_out_frame();
        end

        quiesce();
        repeat (8) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/pwft_pkg.sv
rtl/pwft_out_skid.sv
rtl/pulse_width_frame_transmitter_unit.sv
bench/pwft_line_monitor.sv
bench/tb_top.sv
